FILE: hw/rtl/bfpa_pkg.sv
`timescale 1ns / 1ps

package bfpa_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL_OFF,
        ST_REL_CHK,
        ST_SCAN,
        ST_APPLY,
        ST_FIN
    } state_t;

    // Request modes
    localparam logic [1:0] MODE_PROBE   = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    // Result status codes
    localparam logic [2:0] STS_OK           = 3'd0;
    localparam logic [2:0] STS_STOPPED      = 3'd1;
    localparam logic [2:0] STS_NO_FIT       = 3'd2;
    localparam logic [2:0] STS_OUT_OF_POOL  = 3'd3;
    localparam logic [2:0] STS_ALREADY_FREE = 3'd4;
    localparam logic [2:0] STS_TABLE_FULL   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [1:0] CFG_POOL_PAGES = 2'd1;
    localparam logic [1:0] CFG_HALTED     = 2'd2;

    // Used-page counter and capacity field widths
    localparam int          USED_W      = 29;
    localparam logic [28:0] USED_MAX    = 29'h1FFF_FFFF;
    localparam int          CFG_PAGES_W = 29;

    typedef struct packed {
        logic [1:0]  mode;
        logic [39:0] size_bytes;
        logic [63:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        fits;
        logic [63:0] granted_address;
        logic [40:0] allocated_bytes;
    } out_item_t;

endpackage

FILE: hw/rtl/best_fit_page_allocator.sv
`timescale 1ns / 1ps
// One item at a time; the next is accepted once the result loads. Probe and allocate
// pass ST_SCAN and ST_APPLY to ST_FIN; release passes ST_REL_OFF and ST_REL_CHK first,
// leaving for ST_FIN from either if outside the pool. Halted probe/alloc and no-op items
// skip to ST_FIN. The table is swept one slot per cycle via the single RAM read port.
// Synchronous active-low reset empties the table, clears used pages and control registers.
module best_fit_page_allocator #(
    parameter int FREE_SLOTS      = 64,
    parameter int PAGE_BYTES      = 4096,
    parameter int PAGE_INDEX_BITS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfpa_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfpa_pkg::out_item_t  m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int SH    = $clog2(PAGE_BYTES);
    localparam int SW    = PAGE_INDEX_BITS;
    localparam int PW    = PAGE_INDEX_BITS + 1;
    localparam int IW    = $clog2(FREE_SLOTS);
    localparam int CNTW  = $clog2(FREE_SLOTS + 1);
    localparam int REQ_W = 41 - SH;
    localparam int CW    = ((PW > REQ_W) ? PW : REQ_W) + 1;
    localparam int UW    = ((bfpa_pkg::USED_W > REQ_W) ? bfpa_pkg::USED_W : REQ_W) + 1;
    localparam int EW    = SW + PW;
    localparam logic [63:0] PAGE_LIMIT = 64'd1 << PAGE_INDEX_BITS;

    bfpa_pkg::state_t state_reg, state_next;

    logic [63:0]             pool_base_reg;
    logic [PW-1:0]           pool_pages_reg;
    logic                    halted_reg;
    logic [FREE_SLOTS-1:0]   valid_reg;
    logic [bfpa_pkg::USED_W-1:0] used_reg;

    logic [1:0]              mode_reg;
    logic [REQ_W-1:0]        req_reg;
    logic [63:0]             addr_reg;
    logic [PW-1:0]           pg_reg;
    logic [CNTW-1:0]         cnt_reg;

    logic                    found_reg;
    logic [SW-1:0]           best_start_reg;
    logic [PW-1:0]           best_pages_reg;
    logic [IW-1:0]           best_idx_reg;

    logic                    dup_reg;
    logic                    prev_found_reg;
    logic [SW-1:0]           prev_start_reg;
    logic [PW-1:0]           prev_pages_reg;
    logic [IW-1:0]           prev_idx_reg;
    logic                    next_found_reg;
    logic [PW-1:0]           next_pages_reg;
    logic [IW-1:0]           next_idx_reg;
    logic                    spare_found_reg;
    logic [IW-1:0]           spare_idx_reg;

    logic [2:0]              status_reg;
    logic                    fits_reg;
    logic [63:0]             granted_reg;
    bfpa_pkg::out_item_t     out_reg;
    logic                    m_valid_reg;

    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [EW-1:0]           ram_rdata;

    logic s_fire, cfg_fire, out_load;

    // capacity write value, saturated to the page index range
    logic [63:0] cfg_pages64;
    logic [PW-1:0] cfg_pages;
    assign cfg_pages64 = (64'(cfg_data[bfpa_pkg::CFG_PAGES_W-1:0]) > PAGE_LIMIT) ?
                         PAGE_LIMIT : 64'(cfg_data[bfpa_pkg::CFG_PAGES_W-1:0]);
    assign cfg_pages   = cfg_pages64[PW-1:0];

    // page rounding of the request size
    logic [REQ_W-1:0] req_in;
    assign req_in = REQ_W'(s_item.size_bytes >> SH) + REQ_W'(|s_item.size_bytes[SH-1:0]);

    assign s_ready   = (state_reg == bfpa_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == bfpa_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == bfpa_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;

    // release range checks
    logic [64:0] off_diff;
    logic [63:0] cap, abytes;
    logic        chk_err;
    assign off_diff = {1'b0, addr_reg} - {1'b0, pool_base_reg};
    assign cap      = 64'(pool_pages_reg) << SH;
    assign abytes   = 64'(req_reg) << SH;
    assign chk_err  = (|addr_reg[SH-1:0]) || (addr_reg > cap) || (abytes > (cap - addr_reg));

    // scan: entry read last cycle
    logic [CNTW-1:0] cnt_m1;
    logic [IW-1:0]   e_idx;
    logic            e_on, e_v;
    logic [SW-1:0]   e_start;
    logic [PW-1:0]   e_pages;
    logic [CW-1:0]   req_c, pg_c, pg_end_c, start_c, pages_c;
    logic            fit_cand, prev_cand, next_cand, spare_cand, hit_dup;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign e_idx    = cnt_m1[IW-1:0];
    assign e_on     = (cnt_reg != '0);
    assign e_v      = e_on && valid_reg[e_idx];
    assign e_start  = ram_rdata[PW +: SW];
    assign e_pages  = ram_rdata[PW-1:0];
    assign req_c    = CW'(req_reg);
    assign pg_c     = CW'(pg_reg);
    assign pg_end_c = pg_c + req_c;
    assign start_c  = CW'(e_start);
    assign pages_c  = CW'(e_pages);
    assign fit_cand = e_v && (pages_c >= req_c) &&
                      (!found_reg || (e_pages < best_pages_reg) ||
                       ((e_pages == best_pages_reg) && (e_start < best_start_reg)));
    assign hit_dup   = e_v && (start_c == pg_c);
    assign prev_cand = e_v && (start_c < pg_c) &&
                       (!prev_found_reg || (e_start > prev_start_reg));
    assign next_cand = e_v && (start_c == pg_end_c);
    assign spare_cand = e_on && !valid_reg[e_idx] && !spare_found_reg;

    // apply: allocate
    logic          alloc_exact;
    logic [UW-1:0] used_sum;
    logic [63:0]   grant_addr;
    assign alloc_exact = (CW'(best_pages_reg) == req_c);
    assign used_sum    = UW'(used_reg) + UW'(req_reg);
    assign grant_addr  = pool_base_reg + (64'(best_start_reg) << SH);

    // apply: release
    logic [CW-1:0] prev_end_c, merge_c, next_merge_c;
    logic          overlap, prev_adj, rel_ok, rel_write;
    assign prev_end_c   = CW'(prev_start_reg) + CW'(prev_pages_reg);
    assign overlap      = prev_found_reg && (prev_end_c > pg_c);
    assign prev_adj     = prev_found_reg && (prev_end_c == pg_c);
    assign merge_c      = CW'(prev_pages_reg) + req_c +
                          (next_found_reg ? CW'(next_pages_reg) : CW'(0));
    assign next_merge_c = CW'(next_pages_reg) + req_c;
    assign rel_ok       = !dup_reg && !overlap && (req_reg != '0);
    assign rel_write    = rel_ok && (prev_adj || next_found_reg || spare_found_reg);

    logic [63:0] ab64;
    assign ab64 = 64'(used_reg) << SH;

    // table RAM: {start, pages} per slot
    bfpa_ram #(
        .WIDTH (EW),
        .DEPTH (FREE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (ram_rdata)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state, RAM strobes
    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        case (state_reg)
            bfpa_pkg::ST_IDLE: begin
                if (cfg_fire && (cfg_index == bfpa_pkg::CFG_POOL_PAGES)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {SW'(0), cfg_pages};
                end
                if (s_fire) begin
                    case (s_item.mode)
                        bfpa_pkg::MODE_PROBE,
                        bfpa_pkg::MODE_ALLOC:   state_next = halted_reg ? bfpa_pkg::ST_FIN
                                                                        : bfpa_pkg::ST_SCAN;
                        bfpa_pkg::MODE_RELEASE: state_next = bfpa_pkg::ST_REL_OFF;
                        default:                state_next = bfpa_pkg::ST_FIN;
                    endcase
                end
            end
            bfpa_pkg::ST_REL_OFF: begin
                state_next = off_diff[64] ? bfpa_pkg::ST_FIN : bfpa_pkg::ST_REL_CHK;
            end
            bfpa_pkg::ST_REL_CHK: begin
                state_next = chk_err ? bfpa_pkg::ST_FIN : bfpa_pkg::ST_SCAN;
            end
            bfpa_pkg::ST_SCAN: begin
                ram_re = (cnt_reg < CNTW'(FREE_SLOTS));
                if (cnt_reg == CNTW'(FREE_SLOTS)) begin
                    state_next = bfpa_pkg::ST_APPLY;
                end
            end
            bfpa_pkg::ST_APPLY: begin
                state_next = bfpa_pkg::ST_FIN;
                if (mode_reg == bfpa_pkg::MODE_ALLOC) begin
                    if (found_reg && (req_reg != '0) && !alloc_exact) begin
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = {best_start_reg + SW'(req_reg),
                                     best_pages_reg - PW'(req_reg)};
                    end
                end else if (mode_reg == bfpa_pkg::MODE_RELEASE && rel_write) begin
                    ram_we = 1'b1;
                    if (prev_adj) begin
                        ram_waddr = prev_idx_reg;
                        ram_wdata = {prev_start_reg, merge_c[PW-1:0]};
                    end else if (next_found_reg) begin
                        ram_waddr = next_idx_reg;
                        ram_wdata = {pg_reg[SW-1:0], next_merge_c[PW-1:0]};
                    end else begin
                        ram_waddr = spare_idx_reg;
                        ram_wdata = {pg_reg[SW-1:0], PW'(req_reg)};
                    end
                end
            end
            bfpa_pkg::ST_FIN: begin
                if (out_load) begin
                    state_next = bfpa_pkg::ST_IDLE;
                end
            end
            default: state_next = bfpa_pkg::ST_IDLE;
        endcase
    end

    // control and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg  <= '0;
            pool_pages_reg <= '0;
            halted_reg     <= 1'b0;
            valid_reg      <= '0;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            // config writes
            if (cfg_fire) begin
                case (cfg_index)
                    bfpa_pkg::CFG_POOL_BASE:  pool_base_reg <= cfg_data;
                    bfpa_pkg::CFG_POOL_PAGES: begin
                        pool_pages_reg <= cfg_pages;
                        valid_reg      <= (cfg_pages != '0) ? FREE_SLOTS'(1) : '0;
                        used_reg       <= '0;
                    end
                    bfpa_pkg::CFG_HALTED:     halted_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_fire) begin
                cnt_reg <= '0;
            end
            if (state_reg == bfpa_pkg::ST_SCAN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // table and counter updates
            if (state_reg == bfpa_pkg::ST_APPLY) begin
                if (mode_reg == bfpa_pkg::MODE_ALLOC) begin
                    if (found_reg && (req_reg != '0)) begin
                        if (alloc_exact) begin
                            valid_reg[best_idx_reg] <= 1'b0;
                        end
                        used_reg <= (used_sum > UW'(bfpa_pkg::USED_MAX)) ?
                                    bfpa_pkg::USED_MAX : used_sum[bfpa_pkg::USED_W-1:0];
                    end
                end else if (mode_reg == bfpa_pkg::MODE_RELEASE && rel_write) begin
                    if (prev_adj) begin
                        if (next_found_reg) begin
                            valid_reg[next_idx_reg] <= 1'b0;
                        end
                    end else if (!next_found_reg) begin
                        valid_reg[spare_idx_reg] <= 1'b1;
                    end
                    used_reg <= (UW'(used_reg) < UW'(req_reg)) ? '0 :
                                bfpa_pkg::USED_W'(UW'(used_reg) - UW'(req_reg));
                end
            end
            // result register
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg        <= s_item.mode;
            req_reg         <= req_in;
            addr_reg        <= s_item.block_address;
            status_reg      <= ((s_item.mode == bfpa_pkg::MODE_PROBE ||
                                 s_item.mode == bfpa_pkg::MODE_ALLOC) && halted_reg) ?
                               bfpa_pkg::STS_STOPPED : bfpa_pkg::STS_OK;
            fits_reg        <= 1'b0;
            granted_reg     <= '0;
            found_reg       <= 1'b0;
            dup_reg         <= 1'b0;
            prev_found_reg  <= 1'b0;
            next_found_reg  <= 1'b0;
            spare_found_reg <= 1'b0;
        end
        case (state_reg)
            bfpa_pkg::ST_REL_OFF: begin
                if (off_diff[64]) begin
                    status_reg <= bfpa_pkg::STS_OUT_OF_POOL;
                end else begin
                    addr_reg <= off_diff[63:0];
                end
            end
            bfpa_pkg::ST_REL_CHK: begin
                if (chk_err) begin
                    status_reg <= bfpa_pkg::STS_OUT_OF_POOL;
                end else begin
                    pg_reg <= PW'(addr_reg >> SH);
                end
            end
            bfpa_pkg::ST_SCAN: begin
                if (mode_reg == bfpa_pkg::MODE_RELEASE) begin
                    if (hit_dup) begin
                        dup_reg <= 1'b1;
                    end
                    if (prev_cand) begin
                        prev_found_reg <= 1'b1;
                        prev_start_reg <= e_start;
                        prev_pages_reg <= e_pages;
                        prev_idx_reg   <= e_idx;
                    end
                    if (next_cand) begin
                        next_found_reg <= 1'b1;
                        next_pages_reg <= e_pages;
                        next_idx_reg   <= e_idx;
                    end
                    if (spare_cand) begin
                        spare_found_reg <= 1'b1;
                        spare_idx_reg   <= e_idx;
                    end
                end else if (fit_cand) begin
                    found_reg      <= 1'b1;
                    best_start_reg <= e_start;
                    best_pages_reg <= e_pages;
                    best_idx_reg   <= e_idx;
                end
            end
            bfpa_pkg::ST_APPLY: begin
                case (mode_reg)
                    bfpa_pkg::MODE_PROBE: fits_reg <= found_reg;
                    bfpa_pkg::MODE_ALLOC: begin
                        if (!found_reg) begin
                            status_reg <= bfpa_pkg::STS_NO_FIT;
                        end else begin
                            fits_reg    <= 1'b1;
                            granted_reg <= grant_addr;
                        end
                    end
                    bfpa_pkg::MODE_RELEASE: begin
                        if (dup_reg || overlap) begin
                            status_reg <= bfpa_pkg::STS_ALREADY_FREE;
                        end else if (rel_ok && !rel_write) begin
                            status_reg <= bfpa_pkg::STS_TABLE_FULL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (out_load) begin
            out_reg.status          <= status_reg;
            out_reg.fits            <= fits_reg;
            out_reg.granted_address <= granted_reg;
            out_reg.allocated_bytes <= ab64[40:0];
        end
    end

endmodule

FILE: hw/rtl/bfpa_ram.sv
`timescale 1ns / 1ps

module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: verif/best_fit_page_allocator_tb.sv
`timescale 1ns / 1ps

module best_fit_page_allocator_tb;

    localparam int          SLOTS      = 64;
    localparam logic [63:0] PAGE       = 64'd4096;
    localparam logic [63:0] PAGE_LIMIT = 64'd1 << 28;
    localparam int          SETTLE     = 80;
    localparam int          WATCHDOG   = 5000;

    // Free-range table predictor plus the queue of results still owed
    class alloc_scoreboard;
        logic [63:0] rng_start [SLOTS];
        logic [63:0] rng_pages [SLOTS];
        bit          rng_live  [SLOTS];
        logic [63:0] used_pg, base, cap_pg;
        bit          halt;
        bfpa_pkg::out_item_t owed[$];
        int          errors;
        int          n_results;
        int          n_full;

        function void refill();
            for (int i = 0; i < SLOTS; i++) begin
                rng_start[i] = 0;
                rng_pages[i] = 0;
                rng_live[i]  = 0;
            end
            if (cap_pg != 0) begin
                rng_live[0]  = 1;
                rng_pages[0] = cap_pg;
            end
            used_pg = 0;
        endfunction

        function void clear();
            base   = 0;
            cap_pg = 0;
            halt   = 0;
            refill();
        endfunction

        function void configure(logic [1:0] idx, logic [63:0] data);
            logic [63:0] v;
            case (idx)
                bfpa_pkg::CFG_POOL_BASE: base = data;
                bfpa_pkg::CFG_POOL_PAGES: begin
                    v = data & 64'h1FFF_FFFF;
                    cap_pg = (v > PAGE_LIMIT) ? PAGE_LIMIT : v;
                    refill();
                end
                bfpa_pkg::CFG_HALTED: halt = data[0];
                default: ;
            endcase
        endfunction

        // Smallest range that holds req pages, lowest start on a tie
        function int smallest_fit(logic [63:0] req);
            int b;
            b = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!rng_live[i] || rng_pages[i] < req) continue;
                if (b < 0 || rng_pages[i] < rng_pages[b] ||
                    (rng_pages[i] == rng_pages[b] && rng_start[i] < rng_start[b]))
                    b = i;
            end
            return b;
        endfunction

        function logic [2:0] free_block(logic [63:0] addr, logic [63:0] req);
            logic [63:0] off, cap, pg;
            int prv, nxt, spare;
            bit adj;
            if (addr < base) return bfpa_pkg::STS_OUT_OF_POOL;
            off = addr - base;
            if (off % PAGE != 0) return bfpa_pkg::STS_OUT_OF_POOL;
            cap = cap_pg * PAGE;
            if (off > cap || req * PAGE > cap - off) return bfpa_pkg::STS_OUT_OF_POOL;
            pg = off / PAGE;
            prv = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!rng_live[i]) continue;
                if (rng_start[i] == pg) return bfpa_pkg::STS_ALREADY_FREE;
                if (rng_start[i] < pg && (prv < 0 || rng_start[i] > rng_start[prv]))
                    prv = i;
            end
            if (prv >= 0 && rng_start[prv] + rng_pages[prv] > pg)
                return bfpa_pkg::STS_ALREADY_FREE;
            if (req == 0) return bfpa_pkg::STS_OK;
            adj   = prv >= 0 && rng_start[prv] + rng_pages[prv] == pg;
            nxt   = -1;
            spare = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (rng_live[i] && rng_start[i] == pg + req) nxt = i;
                if (!rng_live[i] && spare < 0) spare = i;
            end
            if (adj) begin
                rng_pages[prv] += req;
                if (nxt >= 0) begin
                    rng_pages[prv] += rng_pages[nxt];
                    rng_live[nxt] = 0;
                end
            end else if (nxt >= 0) begin
                rng_start[nxt] = pg;
                rng_pages[nxt] += req;
            end else begin
                if (spare < 0) return bfpa_pkg::STS_TABLE_FULL;
                rng_live[spare]  = 1;
                rng_start[spare] = pg;
                rng_pages[spare] = req;
            end
            used_pg = (used_pg < req) ? 0 : used_pg - req;
            return bfpa_pkg::STS_OK;
        endfunction

        // Accepted request: advance the table and queue the expected result
        function bfpa_pkg::out_item_t note(bfpa_pkg::in_item_t it);
            bfpa_pkg::out_item_t r;
            logic [63:0] sz, req;
            int b;
            sz  = 64'(it.size_bytes);
            req = sz / PAGE + ((sz % PAGE) != 0 ? 64'd1 : 64'd0);
            r   = '0;
            case (it.mode)
                bfpa_pkg::MODE_PROBE: begin
                    if (halt) r.status = bfpa_pkg::STS_STOPPED;
                    else r.fits = smallest_fit(req) >= 0;
                end
                bfpa_pkg::MODE_ALLOC: begin
                    if (halt) begin
                        r.status = bfpa_pkg::STS_STOPPED;
                    end else begin
                        b = smallest_fit(req);
                        if (b < 0) begin
                            r.status = bfpa_pkg::STS_NO_FIT;
                        end else begin
                            r.fits = 1;
                            r.granted_address = base + rng_start[b] * PAGE;
                            if (req > 0) begin
                                if (rng_pages[b] == req) begin
                                    rng_live[b] = 0;
                                end else begin
                                    rng_start[b] += req;
                                    rng_pages[b] -= req;
                                end
                                used_pg = (req > 64'h1FFF_FFFF - used_pg) ?
                                          64'h1FFF_FFFF : used_pg + req;
                            end
                        end
                    end
                end
                bfpa_pkg::MODE_RELEASE: r.status = free_block(it.block_address, req);
                default: ;
            endcase
            r.allocated_bytes = 41'(used_pg * PAGE);
            owed.push_back(r);
            return r;
        endfunction

        function void check(bfpa_pkg::out_item_t got);
            bfpa_pkg::out_item_t want;
            n_results++;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %p", got);
                return;
            end
            want = owed.pop_front();
            if (got.status === bfpa_pkg::STS_TABLE_FULL) n_full++;
            if (got.status !== want.status || got.fits !== want.fits ||
                got.granted_address !== want.granted_address ||
                got.allocated_bytes !== want.allocated_bytes) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d fits %0d/%0d addr %h/%h bytes %h/%h",
                             want.status, got.status, want.fits, got.fits,
                             want.granted_address, got.granted_address,
                             want.allocated_bytes, got.allocated_bytes);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready;
    bfpa_pkg::in_item_t  s_item;
    logic        m_valid, m_ready;
    bfpa_pkg::out_item_t m_item;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    best_fit_page_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    alloc_scoreboard sb = new();

    logic [63:0] live_addr[$];
    int          live_pages[$];
    logic [63:0] freed_addr[$];
    int          burst_left = 0;
    int          n_sent = 0;
    int          n_cfg = 0;
    int          idle_cycles = 0;
    int          rx_tick = 0;
    int          rx_style = 0;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: stall style is re-picked at random: always ready, coin flip or one in eight
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_item);
        rx_tick <= rx_tick + 1;
        if (rx_tick % 300 == 0) rx_style <= $urandom_range(0, 2);
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired with %0d results owed", sb.owed.size());
            $display("best_fit_page_allocator_tb failed");
            $finish;
        end
    end

    task automatic send(input bfpa_pkg::in_item_t it, output bfpa_pkg::out_item_t exp);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        exp = sb.note(it);
        n_sent++;
        if (it.mode == bfpa_pkg::MODE_ALLOC && exp.status == bfpa_pkg::STS_OK &&
            it.size_bytes != 0) begin
            live_addr.push_back(exp.granted_address);
            live_pages.push_back(int'((64'(it.size_bytes) + PAGE - 1) / PAGE));
        end
    endtask

    task automatic issue(input logic [1:0] md, input logic [39:0] sz, input logic [63:0] ad);
        bfpa_pkg::in_item_t  it;
        bfpa_pkg::out_item_t exp;
        it.mode = md;
        it.size_bytes = sz;
        it.block_address = ad;
        send(it, exp);
    endtask

    // Let the block go idle before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.configure(idx, data);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic setup_pool(input logic [63:0] b, input logic [63:0] pg, input bit h);
        drain();
        cfg_write(bfpa_pkg::CFG_POOL_BASE, b);
        cfg_write(bfpa_pkg::CFG_POOL_PAGES, pg);
        cfg_write(bfpa_pkg::CFG_HALTED, {63'd0, h});
        live_addr.delete();
        live_pages.delete();
        freed_addr.delete();
    endtask

    function automatic logic [39:0] bytes_for(int pg);
        if (pg == 0) return 40'd0;
        return 40'(pg) * 40'd4096 - 40'($urandom_range(0, 4095));
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly allocate/release pairs with random content, some noise
    task automatic random_item();
        int r, k, pg;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            issue(bfpa_pkg::MODE_PROBE, ($urandom_range(0, 3) == 0) ? 40'(rand64()) :
                  bytes_for($urandom_range(0, 40)), rand64());
        end else if (r < 12) begin
            issue(bfpa_pkg::MODE_NOP, 40'(rand64()), rand64());
        end else if (r < 50 || (r < 85 && live_addr.size() == 0)) begin
            pg = ($urandom_range(0, 19) == 0) ? $urandom_range(0, int'(sb.cap_pg) + 1)
                                               : $urandom_range(0, 6);
            issue(bfpa_pkg::MODE_ALLOC, bytes_for(pg), rand64());
        end else if (r < 85) begin
            k = $urandom_range(0, live_addr.size() - 1);
            issue(bfpa_pkg::MODE_RELEASE, bytes_for(live_pages[k]), live_addr[k]);
            freed_addr.push_back(live_addr[k]);
            live_addr.delete(k);
            live_pages.delete(k);
        end else begin
            case ($urandom_range(0, 3))
                0: if (freed_addr.size() != 0)
                       issue(bfpa_pkg::MODE_RELEASE, 40'd4096,
                             freed_addr[$urandom_range(0, freed_addr.size() - 1)]);
                   else
                       issue(bfpa_pkg::MODE_RELEASE, 40'd4096, sb.base);
                1: issue(bfpa_pkg::MODE_RELEASE, 40'd4096,
                         sb.base + 64'($urandom_range(1, 4095)));
                2: issue(bfpa_pkg::MODE_RELEASE, 40'(rand64()), rand64());
                default: issue(bfpa_pkg::MODE_RELEASE, bytes_for($urandom_range(1, 3)),
                               sb.base + sb.cap_pg * PAGE - 64'($urandom_range(0, 2)) * PAGE);
            endcase
        end
    endtask

    initial begin
        logic [63:0] top;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= bfpa_pkg::CFG_POOL_BASE;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        sb.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty pool straight out of reset
        issue(bfpa_pkg::MODE_PROBE, 40'd0, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'd1, 64'd0);
        issue(bfpa_pkg::MODE_RELEASE, 40'd0, 64'd0);

        // Directed: saturated capacity, base near the top of the address space
        top = 64'hFFFF_FFFF_FFFF_0000;
        setup_pool(top, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        issue(bfpa_pkg::MODE_PROBE, 40'd0, 64'd0);
        issue(bfpa_pkg::MODE_PROBE, 40'hFF_FFFF_FFFF, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'hFF_FFFF_FFFF, '1);
        issue(bfpa_pkg::MODE_ALLOC, 40'd1, 64'd0);
        issue(bfpa_pkg::MODE_RELEASE, 40'hFF_FFFF_FFFF, top);
        issue(bfpa_pkg::MODE_ALLOC, 40'd1, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'd4096, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'd4097, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'd0, 64'd0);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top + 64'd1);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top - PAGE);
        issue(bfpa_pkg::MODE_RELEASE, 40'd8192, top + (PAGE_LIMIT - 1) * PAGE);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top + PAGE);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top + PAGE);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top + 100 * PAGE);
        issue(bfpa_pkg::MODE_RELEASE, 40'd0, top);
        issue(bfpa_pkg::MODE_NOP, '1, '1);
        drain();
        cfg_write(bfpa_pkg::CFG_HALTED, 64'd1);
        issue(bfpa_pkg::MODE_PROBE, 40'd1, 64'd0);
        issue(bfpa_pkg::MODE_ALLOC, 40'd1, 64'd0);
        issue(bfpa_pkg::MODE_RELEASE, 40'd4096, top);
        drain();
        cfg_write(bfpa_pkg::CFG_HALTED, 64'd0);
        issue(bfpa_pkg::MODE_PROBE, 40'd8192, 64'd0);

        // Random phases over several pool shapes
        setup_pool(rand64(), $urandom_range(16, 300), 1'b0);
        repeat (90) random_item();
        setup_pool(rand64() & ~64'hFFF, 64'd1, 1'b0);
        repeat (40) random_item();
        setup_pool(64'hFFFF_FFFF_FFFF_F000 - 64'($urandom_range(0, 8)) * PAGE,
                   $urandom_range(20, 64), 1'b0);
        repeat (90) random_item();
        setup_pool(rand64(), $urandom_range(16, 300), 1'b1);
        repeat (20) random_item();
        setup_pool(64'd0, 64'd0, 1'b0);
        repeat (15) random_item();
        setup_pool(rand64(), $urandom_range(100, 400), 1'b0);
        repeat (120) random_item();

        // Fragment the table until releases find no free slot
        setup_pool(rand64(), 64'd160, 1'b0);
        repeat (150) issue(bfpa_pkg::MODE_ALLOC, bytes_for(1), rand64());
        for (int i = 0; i < 150; i += 2)
            issue(bfpa_pkg::MODE_RELEASE, 40'd4096, live_addr[i]);

        drain();
        $display("%0d requests and %0d register writes; %0d results, %0d with table full",
                 n_sent, n_cfg, sb.n_results, sb.n_full);
        if (sb.owed.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("best_fit_page_allocator_tb passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("best_fit_page_allocator_tb failed");
        end
        $finish;
    end

endmodule

FILE: best_fit_page_allocator.f
hw/rtl/bfpa_pkg.sv
hw/rtl/bfpa_ram.sv
hw/rtl/best_fit_page_allocator.sv
verif/best_fit_page_allocator_tb.sv
